>>> hdl/ssp_pkg.sv
`timescale 1ns / 1ps

package ssp_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_X_PHASE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_PHASE = 1'b1;

    // Per-angle coordinate multipliers
    localparam int MUL_X_ADD = 189;
    localparam int MUL_X_SUB = 135;
    localparam int MUL_Y_SUB = 327;
    localparam int MUL_Y_ADD = 201;

    // One sine lookup: magnitude up to 65536 and the sign of the lower half turn
    typedef struct packed {
        logic        neg;
        logic [16:0] mag;
    } sine_t;

endpackage

>>> hdl/ssp_sine_lane.sv
`timescale 1ns / 1ps

module ssp_sine_lane #(
    parameter int PHASE_IDX_BITS = 9
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [15:0]    angle,
    output ssp_pkg::sine_t sine
);

    localparam int QUARTER   = 1 << (PHASE_IDX_BITS - 2);
    localparam int HALF      = 1 << (PHASE_IDX_BITS - 1);
    localparam int ROM_DEPTH = QUARTER + 1;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] SERIES_DIV [16] = '{
        64'd1,   64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930
    };

    // (a*b) >> 60 on Q60 operands, built from 32-bit partial products
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
        al  = {32'd0, a[31:0]};
        ah  = {32'd0, a[63:32]};
        bl  = {32'd0, b[31:0]};
        bh  = {32'd0, b[63:32]};
        ll  = al * bl;
        lh  = al * bh;
        hl  = ah * bl;
        hh  = ah * bh;
        mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
        lo  = {32'd0, ll[31:0]} | (mid << 32);
        hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
        return (hi << 4) | (lo >> 60);
    endfunction

    // Truncated 65536*sin over the first quarter turn, Taylor series in Q60
    function automatic logic [16:0] quarter_sine(input int ab, input int q);
        logic [63:0] x, x2, term, sum, shifted;
        int          quarter;
        quarter = 1 << (ab - 2);
        if (q == 0) begin
            return 17'd0;
        end
        if (q >= quarter) begin
            return 17'd65536;
        end
        x    = (PI_Q60 >> (ab - 1)) * 64'(q);
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n < 16; n++) begin
            term = mul_q60(term, x2) / SERIES_DIV[n];
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        shifted = sum >> 44;
        return shifted[16:0];
    endfunction

    logic [16:0] rom [ROM_DEPTH];

    for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
        assign rom[k] = quarter_sine(PHASE_IDX_BITS, k);
    end

    logic [PHASE_IDX_BITS-1:0] idx;
    logic [PHASE_IDX_BITS-2:0] half_pos;
    logic [PHASE_IDX_BITS-1:0] mirror;
    logic [PHASE_IDX_BITS-2:0] rom_addr;
    ssp_pkg::sine_t            sine_reg;

    // Fold the half turn onto the quarter table
    always_comb begin
        idx      = angle[15 -: PHASE_IDX_BITS];
        half_pos = idx[PHASE_IDX_BITS-2:0];
        mirror   = PHASE_IDX_BITS'(HALF) - {1'b0, half_pos};
        rom_addr = (half_pos <= (PHASE_IDX_BITS-1)'(QUARTER)) ? half_pos
                                                              : mirror[PHASE_IDX_BITS-2:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sine_reg.neg <= idx[PHASE_IDX_BITS-1];
            sine_reg.mag <= rom[rom_addr];
        end
    end

    assign sine = sine_reg;

endmodule

>>> hdl/sine_sum_pixel_palette.sv
`timescale 1ns / 1ps

// Channel  | Direction | tdata fields (lowest bit up)
// ---------+-----------+------------------------------------------------
// s_       | in        | x [COORD_BITS], y [COORD_BITS], zero pad to bytes
// m_       | out       | colour [16] (RGB565), palette_index [8]
// cfg_     | in        | write port: cfg_index 0 x_phase, 1 y_phase
//
// One pixel per cycle sustained while m_tready stays high; the pipeline stages are
// angle form, sine table read, pair add, index, palette.
// Reset clears the stage valid bits and both phase registers.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and a stalled output never drops or repeats a transfer.

module sine_sum_pixel_palette #(
    parameter int PHASE_IDX_BITS = 9,
    parameter int COORD_BITS     = 11
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_wr_en,
    input  logic [ssp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [15:0]                            cfg_wdata,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // x, y, zero padding
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // colour [15:0], palette_index [23:16]
    output logic [23:0]                            m_tdata
);

    localparam int STAGES = 5;
    localparam int PW     = COORD_BITS + 9;

    function automatic logic [15:0] palette_colour(input logic [7:0] index);
        logic [15:0] prod;
        logic [7:0]  j;
        logic [7:0]  r, g, b;
        prod = 16'(index[5:0]) * 16'd1020;
        j    = prod[15:8];
        case (index[7:6])
            2'd0: begin
                r = 8'd255;      g = j;            b = 8'd255 - j;
            end
            2'd1: begin
                r = 8'd255 - j;  g = 8'd255;       b = j;
            end
            2'd2: begin
                r = 8'd0;        g = 8'd255 - j;   b = 8'd255;
            end
            default: begin
                r = j;           g = 8'd0;         b = 8'd255;
            end
        endcase
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    logic [15:0]        x_phase_reg;
    logic [15:0]        y_phase_reg;
    logic [STAGES-1:0]  valid_reg;
    logic [STAGES-1:0]  load;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_phase_reg <= 16'd0;
            y_phase_reg <= 16'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ssp_pkg::CFG_X_PHASE: x_phase_reg <= cfg_wdata;
                ssp_pkg::CFG_Y_PHASE: y_phase_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage loads when empty or when the next stage loads too
    always_comb begin
        load[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (load[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (load[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = load[0];

    // Stage 1: form the four angles
    logic [COORD_BITS-1:0] x_in, y_in;
    logic [PW-1:0]         px_add, px_sub, py_sub, py_add;
    logic [3:0][15:0]      angle_next;
    logic [3:0][15:0]      angle_reg;

    always_comb begin
        x_in   = s_tdata[COORD_BITS-1:0];
        y_in   = s_tdata[2*COORD_BITS-1:COORD_BITS];
        px_add = PW'(x_in) * PW'(ssp_pkg::MUL_X_ADD);
        px_sub = PW'(x_in) * PW'(ssp_pkg::MUL_X_SUB);
        py_sub = PW'(y_in) * PW'(ssp_pkg::MUL_Y_SUB);
        py_add = PW'(y_in) * PW'(ssp_pkg::MUL_Y_ADD);
        angle_next[0] = x_phase_reg + px_add[15:0];
        angle_next[1] = x_phase_reg - px_sub[15:0];
        angle_next[2] = y_phase_reg - py_sub[15:0];
        angle_next[3] = y_phase_reg + py_add[15:0];
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            angle_reg <= angle_next;
        end
    end

    // Stage 2: sine table reads
    ssp_pkg::sine_t sine [4];

    for (genvar i = 0; i < 4; i++) begin : g_lane
        ssp_sine_lane #(
            .PHASE_IDX_BITS (PHASE_IDX_BITS)
        ) u_lane (
            .aclk  (aclk),
            .en    (load[1]),
            .angle (angle_reg[i]),
            .sine  (sine[i])
        );
    end

    // Stage 3: apply signs, add pairs
    logic signed [17:0] sval [4];
    logic signed [18:0] pair_next [2];
    logic signed [18:0] pair_reg [2];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sval[i] = sine[i].neg ? -$signed({1'b0, sine[i].mag})
                                  : $signed({1'b0, sine[i].mag});
        end
        pair_next[0] = 19'(sval[0]) + 19'(sval[1]);
        pair_next[1] = 19'(sval[2]) + 19'(sval[3]);
    end

    always_ff @(posedge aclk) begin
        if (load[2]) begin
            pair_reg[0] <= pair_next[0];
            pair_reg[1] <= pair_next[1];
        end
    end

    // Stage 4: floor quarter, magnitude, clamp, index
    logic signed [19:0] total;
    logic signed [19:0] total_q;
    logic signed [17:0] quarter;
    logic signed [17:0] quarter_abs;
    logic [16:0]        mag;
    logic [7:0]         index_next;
    logic [7:0]         index_reg;

    always_comb begin
        total       = 20'(pair_reg[0]) + 20'(pair_reg[1]);
        total_q     = total >>> 2;
        quarter     = total_q[17:0];
        quarter_abs = quarter[17] ? -quarter : quarter;
        mag         = quarter_abs[16:0];
        index_next  = mag[16] ? 8'hFF : mag[15:8];
    end

    always_ff @(posedge aclk) begin
        if (load[3]) begin
            index_reg <= index_next;
        end
    end

    // Stage 5: palette and output register
    logic [15:0] colour_reg;
    logic [7:0]  out_index_reg;

    always_ff @(posedge aclk) begin
        if (load[4]) begin
            colour_reg    <= palette_colour(index_reg);
            out_index_reg <= index_reg;
        end
    end

    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata  = {out_index_reg, colour_reg};

endmodule
